// File: hw/rtl/mtq_pkg.sv
// Shared types, codes and helpers for the min-tracking queue.
`default_nettype none

package mtq_pkg;

  // Operation codes carried by an input item
  typedef enum logic [1:0] {
    MODE_ENQ  = 2'd0,
    MODE_DEQ  = 2'd1,
    MODE_CLR  = 2'd2,
    MODE_PEEK = 2'd3
  } mode_t;

  // Result status codes
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  localparam int unsigned DATA_W  = 32;
  localparam int unsigned COUNT_W = 11;

  typedef logic signed [DATA_W-1:0] data_t;

  // Front stack entry: value and running minimum down to the stack bottom
  typedef struct packed {
    data_t val;
    data_t rmin;
  } entry_t;

  function automatic data_t smin(input data_t a, input data_t b);
    smin = (a < b) ? a : b;
  endfunction

endpackage : mtq_pkg

`default_nettype wire

// File: hw/rtl/mtq_ifs.sv
// Valid/ready channel interfaces for the min-tracking queue input and result items.
`default_nettype none

interface mtq_in_if
  import mtq_pkg::*;
();
  logic          valid;
  logic          ready;
  mode_t         mode;
  data_t         push_value;

  modport source (output valid, output mode, output push_value, input ready);
  modport sink   (input valid, input mode, input push_value, output ready);
endinterface : mtq_in_if

interface mtq_out_if
  import mtq_pkg::*;
();
  logic                 valid;
  logic                 ready;
  status_t              status;
  data_t                removed_value;
  data_t                front_value;
  data_t                min_value;
  logic [COUNT_W-1:0]   count;

  modport source (output valid, output status, output removed_value, output front_value,
                  output min_value, output count, input ready);
  modport sink   (input valid, input status, input removed_value, input front_value,
                  input min_value, input count, output ready);
endinterface : mtq_out_if

`default_nettype wire

// File: hw/rtl/min_tracking_queue.sv
// Enqueue, clear, peek and rejected items go from the accept straight to the emit step;
// a dequeue from a filled front stack drops the top and reloads the entry below, if any.
// A dequeue that finds the front stack empty first moves the back stack over one
// entry per cycle through the back memory read port before it drops the top.
// Items are accepted only in the idle state, one item at a time; a result
// waiting in the output register holds the next item in its emit step and blocks accept.
// Reset (rst_n low, synchronous) empties the queue at once; memories are not cleared.
`default_nettype none

module min_tracking_queue
  import mtq_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = 1024
) (
  input  wire         clk,
  input  wire         rst_n,
  mtq_in_if.sink      in_ch,
  mtq_out_if.source   out_ch
);

  localparam int unsigned AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned DW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [DW:0] FULL_CNT = (DW+1)'(QUEUE_DEPTH);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_XFER = 5'b00010,
    S_DEQ  = 5'b00100,
    S_LOAD = 5'b01000,
    S_EMIT = 5'b10000
  } state_t;

  // Stack memories
  data_t  back_mem  [QUEUE_DEPTH];
  entry_t front_mem [QUEUE_DEPTH];

  state_t          state_r, state_nxt;
  logic [DW-1:0]   bd_r, bd_nxt;
  logic [DW-1:0]   fd_r, fd_nxt;
  logic            xv_r, xv_nxt;
  logic            out_valid_r, out_valid_nxt;

  data_t           ft_val_r, ft_val_nxt;
  data_t           ft_min_r, ft_min_nxt;
  data_t           back_min_r, back_min_nxt;
  data_t           back_bot_r, back_bot_nxt;
  status_t         status_r, status_nxt;
  data_t           removed_r, removed_nxt;

  data_t           back_rdata_r;
  entry_t          front_rdata_r;

  status_t             out_status_r;
  data_t               out_removed_r;
  data_t               out_front_r;
  data_t               out_min_r;
  logic [COUNT_W-1:0]  out_count_r;

  logic            back_we;
  logic            front_we;
  logic            out_load;
  logic [DW-1:0]   bd_dec;
  logic [DW-1:0]   fd_dec2;
  logic [AW-1:0]   back_raddr;
  logic [AW-1:0]   front_raddr;
  logic [DW:0]     total;
  logic            full;
  logic            empty;
  data_t           xfer_min;
  data_t           rep_front;
  data_t           rep_min;

  // Derived addresses and status
  assign bd_dec      = bd_r - DW'(1);
  assign fd_dec2     = fd_r - DW'(2);
  assign back_raddr  = bd_dec[AW-1:0];
  assign front_raddr = fd_dec2[AW-1:0];
  assign total       = {1'b0, bd_r} + {1'b0, fd_r};
  assign full        = (total >= FULL_CNT);
  assign empty       = (total == '0);
  assign xfer_min    = (fd_r == '0) ? back_rdata_r : smin(ft_min_r, back_rdata_r);

  // Report from the cached front stack top, back stack bottom and running minima
  always_comb begin
    rep_front = '0;
    rep_min   = '0;
    if (fd_r != '0) begin
      rep_front = ft_val_r;
      rep_min   = (bd_r != '0) ? smin(ft_min_r, back_min_r) : ft_min_r;
    end else if (bd_r != '0) begin
      rep_front = back_bot_r;
      rep_min   = back_min_r;
    end
  end

  // Sequence one item
  always_comb begin
    state_nxt    = state_r;
    bd_nxt       = bd_r;
    fd_nxt       = fd_r;
    xv_nxt       = 1'b0;
    ft_val_nxt   = ft_val_r;
    ft_min_nxt   = ft_min_r;
    back_min_nxt = back_min_r;
    back_bot_nxt = back_bot_r;
    status_nxt   = status_r;
    removed_nxt  = removed_r;
    back_we      = 1'b0;
    front_we     = 1'b0;
    out_load     = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (in_ch.valid) begin
          state_nxt   = S_EMIT;
          status_nxt  = ST_OK;
          removed_nxt = '0;
          case (in_ch.mode)
            MODE_ENQ: begin
              if (full) begin
                status_nxt = ST_FULL;
              end else begin
                back_we = 1'b1;
                bd_nxt  = bd_r + DW'(1);
                if (bd_r == '0) begin
                  back_min_nxt = in_ch.push_value;
                  back_bot_nxt = in_ch.push_value;
                end else begin
                  back_min_nxt = smin(back_min_r, in_ch.push_value);
                end
              end
            end
            MODE_DEQ: begin
              if (empty) begin
                status_nxt = ST_EMPTY;
              end else if (fd_r == '0) begin
                state_nxt = S_XFER;
              end else begin
                state_nxt = S_DEQ;
              end
            end
            MODE_CLR: begin
              bd_nxt = '0;
              fd_nxt = '0;
            end
            default: begin
              if (empty) begin
                status_nxt = ST_EMPTY;
              end
            end
          endcase
        end
      end
      S_XFER: begin
        // advance the back read; write what came back last cycle
        if (bd_r != '0) begin
          bd_nxt = bd_dec;
          xv_nxt = 1'b1;
        end
        if (xv_r) begin
          front_we   = 1'b1;
          fd_nxt     = fd_r + DW'(1);
          ft_val_nxt = back_rdata_r;
          ft_min_nxt = xfer_min;
        end
        if ((bd_r == '0) && !xv_r) begin
          state_nxt = S_DEQ;
        end
      end
      S_DEQ: begin
        // drop the top; fetch the entry below when one is left
        removed_nxt = ft_val_r;
        fd_nxt      = fd_r - DW'(1);
        state_nxt   = (fd_r > DW'(1)) ? S_LOAD : S_EMIT;
      end
      S_LOAD: begin
        ft_val_nxt = front_rdata_r.val;
        ft_min_nxt = front_rdata_r.rmin;
        state_nxt  = S_EMIT;
      end
      S_EMIT: begin
        if (!out_valid_r || out_ch.ready) begin
          out_load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign out_valid_nxt = out_load | (out_valid_r & ~out_ch.ready);

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      bd_r        <= '0;
      fd_r        <= '0;
      xv_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      bd_r        <= bd_nxt;
      fd_r        <= fd_nxt;
      xv_r        <= xv_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    ft_val_r   <= ft_val_nxt;
    ft_min_r   <= ft_min_nxt;
    back_min_r <= back_min_nxt;
    back_bot_r <= back_bot_nxt;
    status_r   <= status_nxt;
    removed_r  <= removed_nxt;
    if (out_load) begin
      out_status_r  <= status_r;
      out_removed_r <= removed_r;
      out_front_r   <= rep_front;
      out_min_r     <= rep_min;
      out_count_r   <= COUNT_W'(total);
    end
  end

  // Back stack memory
  always_ff @(posedge clk) begin
    if (back_we) begin
      back_mem[bd_r[AW-1:0]] <= in_ch.push_value;
    end
    back_rdata_r <= back_mem[back_raddr];
  end

  // Front stack memory
  always_ff @(posedge clk) begin
    if (front_we) begin
      front_mem[fd_r[AW-1:0]] <= '{val: back_rdata_r, rmin: xfer_min};
    end
    front_rdata_r <= front_mem[front_raddr];
  end

  // Channel ports
  assign in_ch.ready          = (state_r == S_IDLE);
  assign out_ch.valid         = out_valid_r;
  assign out_ch.status        = out_status_r;
  assign out_ch.removed_value = out_removed_r;
  assign out_ch.front_value   = out_front_r;
  assign out_ch.min_value     = out_min_r;
  assign out_ch.count         = out_count_r;

endmodule : min_tracking_queue

`default_nettype wire

// File: bench/tb_min_tracking_queue.sv
// Testbench for min_tracking_queue: directed table and random items.
`timescale 1ns / 1ps

module tb_min_tracking_queue;
  import mtq_pkg::*;

  localparam int unsigned DEPTH      = 1024;
  localparam int          N_DIRECTED = 20;
  localparam int          N_RANDOM   = 380;
  localparam int          N_CALM     = 80;
  localparam int          MAX_SHOWN  = 10;
  localparam longint      CYCLE_CAP  = 500000;

  // One result item as the queue reports it
  typedef struct packed {
    status_t            status;
    data_t              removed;
    data_t              front;
    data_t              minv;
    logic [COUNT_W-1:0] count;
  } result_t;

  // One row of the directed table; want is used only where typed is set
  typedef struct packed {
    mode_t   mode;
    data_t   value;
    bit      typed;
    result_t want;
  } op_row_t;

  logic clk = 1'b0;
  logic rst_n;

  mtq_in_if  in_ch ();
  mtq_out_if out_ch ();

  min_tracking_queue #(
    .QUEUE_DEPTH(DEPTH)
  ) u_dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Mirror of the two stacks; the top of each stack is the last element
  entry_t  back_stk[$];
  entry_t  front_stk[$];
  result_t pending[$];

  bit      idle_en = 1'b1;
  int      mism_cnt = 0;
  longint  cycle_cnt = 0;
  op_row_t dir_tab[N_DIRECTED];
  result_t no_want = '0;

  function automatic data_t lesser(input data_t a, input data_t b);
    return ($signed(a) < $signed(b)) ? a : b;
  endfunction

  // Report the queue as it stands now
  function automatic result_t queue_state(input status_t st, input data_t taken);
    result_t r;
    r.status  = st;
    r.removed = taken;
    r.count   = COUNT_W'(back_stk.size() + front_stk.size());
    r.front   = '0;
    r.minv    = '0;
    if (front_stk.size() > 0) begin
      r.front = front_stk[$].val;
      r.minv  = front_stk[$].rmin;
      if (back_stk.size() > 0) r.minv = lesser(r.minv, back_stk[$].rmin);
    end else if (back_stk.size() > 0) begin
      r.front = back_stk[0].val;
      r.minv  = back_stk[$].rmin;
    end
    return r;
  endfunction

  // Apply one item to the mirrored stacks and return the result it causes
  function automatic result_t apply_op(input mode_t m, input data_t v);
    entry_t      e;
    data_t       taken;
    int unsigned held;
    held  = back_stk.size() + front_stk.size();
    taken = '0;
    case (m)
      MODE_ENQ: begin
        if (held >= DEPTH) return queue_state(ST_FULL, '0);
        e.val  = v;
        e.rmin = (back_stk.size() == 0) ? v : lesser(back_stk[$].rmin, v);
        back_stk.push_back(e);
      end
      MODE_DEQ: begin
        if (held == 0) return queue_state(ST_EMPTY, '0);
        // move the whole back stack over, rebuilding the running minima
        if (front_stk.size() == 0) begin
          while (back_stk.size() > 0 && front_stk.size() < DEPTH) begin
            e = back_stk.pop_back();
            if (front_stk.size() > 0) e.rmin = lesser(front_stk[$].rmin, e.val);
            else e.rmin = e.val;
            front_stk.push_back(e);
          end
        end
        e     = front_stk.pop_back();
        taken = e.val;
      end
      MODE_CLR: begin
        back_stk.delete();
        front_stk.delete();
      end
      default: begin
        if (held == 0) return queue_state(ST_EMPTY, '0);
      end
    endcase
    return queue_state(ST_OK, taken);
  endfunction

  // Mix extremes, a narrow band (ties in the minimum) and full-range values
  function automatic data_t rand_value();
    case ($urandom_range(0, 9))
      0:       return 32'sh7FFF_FFFF;
      1:       return 32'sh8000_0000;
      2, 3:    return data_t'($urandom_range(0, 16)) - 32'sd8;
      default: return data_t'($urandom);
    endcase
  endfunction

  // Drive one item, wait for the accept, then log its expected result
  task automatic send_item(input mode_t m, input data_t v, input bit use_want,
                           input result_t want);
    result_t predicted;
    @(negedge clk);
    if (idle_en && $urandom_range(0, 3) == 0) begin
      in_ch.valid = 1'b0;
      repeat ($urandom_range(1, 11)) @(negedge clk);
    end
    in_ch.valid      = 1'b1;
    in_ch.mode       = m;
    in_ch.push_value = v;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    predicted = apply_op(m, v);
    pending.push_back(use_want ? want : predicted);
  endtask

  // Hold off the sender until every expected result has come back
  task automatic drain_results();
    @(negedge clk);
    in_ch.valid = 1'b0;
    while (pending.size() != 0) @(posedge clk);
  endtask

  task automatic note_mismatch(input string field, input longint want, input longint got);
    mism_cnt++;
    if (mism_cnt <= MAX_SHOWN)
      $display("mismatch %s: expected %0d, got %0d", field, want, got);
  endtask

  // Receiver: stall in random bursts while idling is enabled
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (idle_en && rst_n && $urandom_range(0, 5) == 0) begin
        out_ch.ready = 1'b0;
        repeat ($urandom_range(1, 11)) @(negedge clk);
      end
      out_ch.ready = rst_n;
    end
  end

  // Check each result item against the oldest expectation; bound the run
  always @(posedge clk) begin
    result_t want;
    cycle_cnt++;
    if (cycle_cnt > CYCLE_CAP) begin
      $display("tb_min_tracking_queue: FAIL");
      $finish;
    end else if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending.size() == 0) begin
        note_mismatch("unexpected result, count", -1, longint'(out_ch.count));
      end else begin
        want = pending.pop_front();
        if (out_ch.status !== want.status)
          note_mismatch("status", longint'(want.status), longint'(out_ch.status));
        if (out_ch.removed_value !== want.removed)
          note_mismatch("removed_value", longint'(want.removed),
                        longint'(out_ch.removed_value));
        if (out_ch.front_value !== want.front)
          note_mismatch("front_value", longint'(want.front), longint'(out_ch.front_value));
        if (out_ch.min_value !== want.minv)
          note_mismatch("min_value", longint'(want.minv), longint'(out_ch.min_value));
        if (out_ch.count !== want.count)
          note_mismatch("count", longint'(want.count), longint'(out_ch.count));
      end
    end
  end

  initial begin
    mode_t m;
    int    pick;
    rst_n            = 1'b0;
    in_ch.valid      = 1'b0;
    in_ch.mode       = MODE_PEEK;
    in_ch.push_value = '0;

    // Directed rows: empty queue, extremes, transfers, ties, clear
    dir_tab = '{
      '{MODE_PEEK, 32'sh0000_0000, 1'b1, '{ST_EMPTY, 0, 0, 0, 0}},
      '{MODE_DEQ,  32'sh1234_5678, 1'b1, '{ST_EMPTY, 0, 0, 0, 0}},
      '{MODE_CLR,  32'shFFFF_FFFF, 1'b1, '{ST_OK, 0, 0, 0, 0}},
      '{MODE_ENQ,  32'sh7FFF_FFFF, 1'b1,
        '{ST_OK, 0, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 1}},
      '{MODE_ENQ,  32'sh8000_0000, 1'b1,
        '{ST_OK, 0, 32'sh7FFF_FFFF, 32'sh8000_0000, 2}},
      '{MODE_PEEK, 32'shDEAD_BEEF, 1'b1,
        '{ST_OK, 0, 32'sh7FFF_FFFF, 32'sh8000_0000, 2}},
      '{MODE_ENQ,  32'sh0000_0000, 1'b0, '0},
      '{MODE_DEQ,  32'shFFFF_FFFF, 1'b1,
        '{ST_OK, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh8000_0000, 2}},
      '{MODE_ENQ,  -32'sd5,        1'b0, '0},
      '{MODE_DEQ,  32'sh0000_0000, 1'b0, '0},
      '{MODE_DEQ,  32'sh5555_5555, 1'b0, '0},
      '{MODE_PEEK, 32'shAAAA_AAAA, 1'b0, '0},
      '{MODE_ENQ,  32'sd3,         1'b0, '0},
      '{MODE_ENQ,  -32'sd5,        1'b0, '0},
      '{MODE_DEQ,  32'sh0000_0001, 1'b0, '0},
      '{MODE_CLR,  32'sh8000_0000, 1'b1, '{ST_OK, 0, 0, 0, 0}},
      '{MODE_PEEK, 32'sh7FFF_FFFF, 1'b1, '{ST_EMPTY, 0, 0, 0, 0}},
      '{MODE_ENQ,  32'sd1,         1'b0, '0},
      '{MODE_DEQ,  32'sh0F0F_0F0F, 1'b0, '0},
      '{MODE_DEQ,  32'shF0F0_F0F0, 1'b1, '{ST_EMPTY, 0, 0, 0, 0}}
    };

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    foreach (dir_tab[i])
      send_item(dir_tab[i].mode, dir_tab[i].value, dir_tab[i].typed, dir_tab[i].want);
    drain_results();

    // Random mix; the tail runs with no idling on either side
    for (int n = 0; n < N_RANDOM; n++) begin
      if (n == N_RANDOM - N_CALM) idle_en = 1'b0;
      pick = $urandom_range(0, 99);
      if (pick < 45)      m = MODE_ENQ;
      else if (pick < 80) m = MODE_DEQ;
      else if (pick < 94) m = MODE_PEEK;
      else                m = MODE_CLR;
      send_item(m, rand_value(), 1'b0, no_want);
    end

    drain_results();
    repeat (20) @(posedge clk);
    if (mism_cnt == 0) begin
      $display("tb_min_tracking_queue: PASS");
    end else begin
      $display("tb_min_tracking_queue: FAIL");
    end
    $finish;
  end

endmodule : tb_min_tracking_queue
